// ===== rtl/core/beem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_pkg
// Types, widths and command codes shared by the Beeman integrator blocks.
// ----------------------------------------------------------------------------
package beem_pkg;

    // Field and arithmetic widths
    localparam int DATA_W     = 32;
    localparam int AXES       = 2;
    localparam int MUL_W      = DATA_W + 1;      // signed operand, holds unsigned 32
    localparam int PROD_W     = 2 * MUL_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int NUM_W      = DATA_W + 4;      // 2*a2 + 5*a1 - a0 fits here
    localparam int DIV_STEP   = 8;               // quotient bits per cycle
    localparam int DIV_CHUNKS = 5;
    localparam int DIV_W      = DIV_STEP * DIV_CHUNKS;
    localparam int DIV_CNT_W  = $clog2(DIV_CHUNKS);
    localparam int REM_W      = 3;
    localparam logic [REM_W:0] DIVISOR = 4'd6;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_MASS    = 3'd0,
        REG_STEP_SIZE   = 3'd1,
        REG_START_POS_X = 3'd2,
        REG_START_POS_Y = 3'd3,
        REG_START_VEL_X = 3'd4,
        REG_START_VEL_Y = 3'd5
    } cfg_reg_t;

    // Operand pairs of the shared multiplier
    typedef enum logic [2:0] {
        MOP_ACC = 3'd0,   // force * inverse mass
        MOP_VDT = 3'd1,   // velocity * dt
        MOP_DT2 = 3'd2,   // dt * dt
        MOP_CDT = 3'd3,   // position term * dt^2
        MOP_SDT = 3'd4    // velocity term * dt
    } mul_op_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
    } force_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_force;
        logic    mul_en;
        mul_op_t mul_op;
        logic    push_accel;
        logic    take_vdt;
        logic    div_start;
        logic    take_dt2;
        logic    take_pos;
        logic    commit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
    } dp_stat_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if ((&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]))
            r = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    // Clamp a non-negative product to the unsigned 32-bit range
    function automatic logic [DATA_W-1:0] sat_u32(input logic signed [PROD_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (|v[PROD_W-1:DATA_W])
            r = {DATA_W{1'b1}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/beem_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface beem_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/beeman_integrator_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beeman_integrator_2d
// Two-axis Beeman integrator for one body in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   forces : sink channel, one request per time step carrying force_x/force_y.
//   states : source channel, one request per step with the new position and
//            velocity, saturated to the signed 32-bit range.
//   cfg_*  : write port for inverse mass, step size and start position and
//            velocity; write only while no step is in flight. A start write
//            also loads the body state immediately.
// Timing:
//   A new force is taken only after the previous step has finished. The pace
//   is set by the single multiplier per axis (five products in sequence) and
//   the divide-by-six units, which produce eight quotient bits per cycle.
// Reset:
//   Position, velocity and acceleration history clear to zero; inverse mass
//   and step size reset to 1.0.
// Back-pressure:
//   A result waits in the state registers while the next step is computed;
//   the next step holds before its update until that result is taken.
// ----------------------------------------------------------------------------
module beeman_integrator_2d
    import beem_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    beem_stream_if.sink          forces,
    beem_stream_if.source        states
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    force_t   force_data;
    result_t  result_data;
    logic     in_ready;
    logic     out_valid;

    assign force_data   = forces.data;
    assign forces.ready = in_ready;
    assign states.valid = out_valid;
    assign states.data  = result_data;

    beem_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (forces.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (states.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    beem_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .force_data  (force_data),
        .cmd         (cmd),
        .stat        (stat),
        .result_data (result_data)
    );

endmodule

// ===== rtl/core/beem_div6.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_div6
// Signed divide by six, truncating toward zero, eight quotient bits a cycle.
// Quotient is clamped to the signed 32-bit range.
// ----------------------------------------------------------------------------
module beem_div6
    import beem_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [NUM_W-1:0]  num,
    output logic                     last,
    output logic signed [DATA_W-1:0] quo
);

    logic                   busy_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   neg_reg;
    logic [DIV_W-1:0]       mag_reg;
    logic [DIV_W-1:0]       mag_next;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;
    logic [NUM_W-1:0]       num_abs;
    logic signed [DIV_W:0]  quo_wide;

    // Magnitude of the dividend
    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // Restoring steps: dividend bits leave at the top, quotient bits enter below
    always_comb
    begin
        logic [REM_W:0] t;
        mag_next = mag_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            t        = {rem_next, mag_next[DIV_W-1]};
            mag_next = {mag_next[DIV_W-2:0], 1'b0};
            if (t >= DIVISOR)
            begin
                rem_next    = REM_W'(t - DIVISOR);
                mag_next[0] = 1'b1;
            end
            else
            begin
                rem_next = t[REM_W-1:0];
            end
        end
    end

    assign last = busy_reg && (cnt_reg == DIV_CNT_W'(DIV_CHUNKS - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
                busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= {{(DIV_W-NUM_W){1'b0}}, num_abs};
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    // Apply sign, then clamp
    assign quo_wide = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign quo      = sat_s32({{(SUM_W-DIV_W-1){quo_wide[DIV_W]}}, quo_wide});

endmodule

// ===== rtl/core/beem_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_datapath
// Per-axis lanes: acceleration history, one shared multiplier per lane,
// two divide-by-six units, position and velocity state.
// ----------------------------------------------------------------------------
module beem_datapath
    import beem_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  force_t               force_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output result_t              result_data
);

    logic [DATA_W-1:0] im_reg;
    logic [DATA_W-1:0] dt_reg;
    logic              wr_im;
    logic              wr_dt;
    logic [AXES-1:0]   wr_pos;
    logic [AXES-1:0]   wr_vel;
    logic [AXES-1:0]   lane_last;
    logic [AXES-1:0]   lane_last_s;

    logic signed [DATA_W-1:0] force_in   [AXES];
    logic signed [DATA_W-1:0] force_reg  [AXES];
    logic signed [DATA_W-1:0] pos_reg    [AXES];
    logic signed [DATA_W-1:0] vel_reg    [AXES];
    logic signed [DATA_W-1:0] pos_new_reg[AXES];
    logic signed [DATA_W-1:0] h0_reg     [AXES];
    logic signed [DATA_W-1:0] h1_reg     [AXES];
    logic signed [DATA_W-1:0] h2_reg     [AXES];
    logic        [DATA_W-1:0] dt2_reg    [AXES];
    logic signed [SUM_W-1:0]  pacc_reg   [AXES];
    logic signed [PROD_W-1:0] prod_reg   [AXES];
    logic signed [PROD_W-1:0] prod_fl    [AXES];
    logic signed [SUM_W-1:0]  prod_ext   [AXES];
    logic signed [MUL_W-1:0]  mul_a      [AXES];
    logic signed [MUL_W-1:0]  mul_b      [AXES];
    logic signed [NUM_W-1:0]  c_num      [AXES];
    logic signed [NUM_W-1:0]  s_num      [AXES];
    logic signed [DATA_W-1:0] c6         [AXES];
    logic signed [DATA_W-1:0] s6         [AXES];

    // Decode configuration writes
    always_comb
    begin
        wr_im  = 1'b0;
        wr_dt  = 1'b0;
        wr_pos = '0;
        wr_vel = '0;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INV_MASS:    wr_im     = 1'b1;
                REG_STEP_SIZE:   wr_dt     = 1'b1;
                REG_START_POS_X: wr_pos[0] = 1'b1;
                REG_START_POS_Y: wr_pos[1] = 1'b1;
                REG_START_VEL_X: wr_vel[0] = 1'b1;
                REG_START_VEL_Y: wr_vel[1] = 1'b1;
                default:         wr_im     = 1'b0;
            endcase
        end
    end

    // Mass and step registers, reset to one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            im_reg <= DATA_W'(1) << FRAC_BITS;
            dt_reg <= DATA_W'(1) << FRAC_BITS;
        end
        else
        begin
            if (wr_im)
                im_reg <= cfg_data;
            if (wr_dt)
                dt_reg <= cfg_data;
        end
    end

    assign force_in[0] = force_data.force_x;
    assign force_in[1] = force_data.force_y;

    for (genvar ax = 0; ax < AXES; ax++)
    begin : g_lane

        // Select multiplier operands
        always_comb
        begin
            unique case (cmd.mul_op)
                MOP_ACC:
                begin
                    mul_a[ax] = {force_reg[ax][DATA_W-1], force_reg[ax]};
                    mul_b[ax] = {1'b0, im_reg};
                end
                MOP_VDT:
                begin
                    mul_a[ax] = {vel_reg[ax][DATA_W-1], vel_reg[ax]};
                    mul_b[ax] = {1'b0, dt_reg};
                end
                MOP_DT2:
                begin
                    mul_a[ax] = {1'b0, dt_reg};
                    mul_b[ax] = {1'b0, dt_reg};
                end
                MOP_CDT:
                begin
                    mul_a[ax] = {c6[ax][DATA_W-1], c6[ax]};
                    mul_b[ax] = {1'b0, dt2_reg[ax]};
                end
                MOP_SDT:
                begin
                    mul_a[ax] = {s6[ax][DATA_W-1], s6[ax]};
                    mul_b[ax] = {1'b0, dt_reg};
                end
                default:
                begin
                    mul_a[ax] = '0;
                    mul_b[ax] = '0;
                end
            endcase
        end

        // Register the product; shift right with floor rounding
        always_ff @(posedge clk)
        begin
            if (cmd.mul_en)
                prod_reg[ax] <= mul_a[ax] * mul_b[ax];
        end

        assign prod_fl[ax]  = prod_reg[ax] >>> FRAC_BITS;
        assign prod_ext[ax] = {{(SUM_W-PROD_W){prod_fl[ax][PROD_W-1]}}, prod_fl[ax]};

        // Numerators of the two correction terms
        assign c_num[ax] = ({{(NUM_W-DATA_W){h1_reg[ax][DATA_W-1]}}, h1_reg[ax]} <<< 2)
                         - {{(NUM_W-DATA_W){h0_reg[ax][DATA_W-1]}}, h0_reg[ax]};
        assign s_num[ax] = ({{(NUM_W-DATA_W){h2_reg[ax][DATA_W-1]}}, h2_reg[ax]} <<< 1)
                         + ({{(NUM_W-DATA_W){h1_reg[ax][DATA_W-1]}}, h1_reg[ax]} <<< 2)
                         + {{(NUM_W-DATA_W){h1_reg[ax][DATA_W-1]}}, h1_reg[ax]}
                         - {{(NUM_W-DATA_W){h0_reg[ax][DATA_W-1]}}, h0_reg[ax]};

        beem_div6 u_div_c
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cmd.div_start),
            .num   (c_num[ax]),
            .last  (lane_last[ax]),
            .quo   (c6[ax])
        );

        beem_div6 u_div_s
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (cmd.div_start),
            .num   (s_num[ax]),
            .last  (lane_last_s[ax]),
            .quo   (s6[ax])
        );

        // Acceleration history and body state
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                h0_reg[ax]  <= '0;
                h1_reg[ax]  <= '0;
                h2_reg[ax]  <= '0;
                pos_reg[ax] <= '0;
                vel_reg[ax] <= '0;
            end
            else
            begin
                if (cmd.push_accel)
                begin
                    h0_reg[ax] <= h1_reg[ax];
                    h1_reg[ax] <= h2_reg[ax];
                    h2_reg[ax] <= sat_s32(prod_ext[ax]);
                end
                if (wr_pos[ax])
                    pos_reg[ax] <= cfg_data;
                else if (cmd.commit)
                    pos_reg[ax] <= pos_new_reg[ax];
                if (wr_vel[ax])
                    vel_reg[ax] <= cfg_data;
                else if (cmd.commit)
                    vel_reg[ax] <= sat_s32({{(SUM_W-DATA_W){vel_reg[ax][DATA_W-1]}},
                                            vel_reg[ax]} + prod_ext[ax]);
            end
        end

        // Intermediate terms
        always_ff @(posedge clk)
        begin
            if (cmd.load_force)
                force_reg[ax] <= force_in[ax];
            if (cmd.take_vdt)
                pacc_reg[ax] <= {{(SUM_W-DATA_W){pos_reg[ax][DATA_W-1]}}, pos_reg[ax]}
                              + prod_ext[ax];
            if (cmd.take_dt2)
                dt2_reg[ax] <= sat_u32(prod_fl[ax]);
            if (cmd.take_pos)
                pos_new_reg[ax] <= sat_s32(pacc_reg[ax] + prod_ext[ax]);
        end
    end

    // All dividers run in lockstep
    assign stat.div_last = (&lane_last) && (&lane_last_s);

    // State registers double as the result register
    assign result_data.pos_x = pos_reg[0];
    assign result_data.pos_y = pos_reg[1];
    assign result_data.vel_x = vel_reg[0];
    assign result_data.vel_y = vel_reg[1];

endmodule

// ===== rtl/core/beem_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_ctrl
// Step sequencer: issues multiplier, divider and update commands for one
// time step and owns the request handshakes.
// ----------------------------------------------------------------------------
module beem_ctrl
    import beem_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ACC  = 8'b0000_0010,
        ST_VDT  = 8'b0000_0100,
        ST_DT2  = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_CDT  = 8'b0010_0000,
        ST_SDT  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Sequence one step
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_force = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_ACC;
                state_next = ST_VDT;
            end
            ST_VDT:
            begin
                cmd.push_accel = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_op     = MOP_VDT;
                state_next     = ST_DT2;
            end
            ST_DT2:
            begin
                cmd.take_vdt  = 1'b1;
                cmd.div_start = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_op    = MOP_DT2;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.take_dt2 = 1'b1;
                if (stat.div_last)
                    state_next = ST_CDT;
            end
            ST_CDT:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MOP_CDT;
                state_next = ST_SDT;
            end
            ST_SDT:
            begin
                cmd.take_pos = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MOP_SDT;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the previous result is taken
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/beem_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beem_checker
// Port-level checks of the integrator's request handshakes.
// ----------------------------------------------------------------------------
module beem_checker
    import beem_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

    // One step at a time: no new force right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("force accepted while a step is in flight");

    // A fresh result marks the end of a step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
    else $error("result appeared while a step is still in flight");

endmodule

bind beeman_integrator_2d beem_checker u_beem_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (forces.valid),
    .in_ready  (forces.ready),
    .out_valid (states.valid),
    .out_ready (states.ready),
    .out_data  (states.data)
);

// ===== tb/tb_beeman_integrator_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beeman_integrator_2d
// Drives force requests into the two-axis Beeman integrator and checks every
// state request against a fixed-point predictor kept in step with the block.
// Directed steps cover field extremes, saturation, zero and full-scale mass
// and step size, spare register indexes and immediate start loads. Random
// bursts under changing settings and random idling on both channels follow.
// ----------------------------------------------------------------------------
module tb_beeman_integrator_2d;
    import beem_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_IDLE    = 5;
    localparam int RANDOM_GOAL = 2000;
    localparam int DRAIN_WAIT  = 24;
    localparam int TIMEOUT_NS  = 1_000_000;

    // Indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] ONE_Q   = 32'd1 << FRAC_BITS;
    localparam logic [DATA_W-1:0] MAX_S32 = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_S32 = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MAX_U32 = 32'hFFFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    beem_stream_if #(.data_t(force_t))  force_ch ();
    beem_stream_if #(.data_t(result_t)) state_ch ();

    // Pending force requests and predicted states
    force_t  force_queue [$];
    result_t expected_states [$];

    int steps_queued   = 0;
    int steps_reported = 0;
    int fail_count     = 0;

    bit pace_gaps   = 1'b1;
    bit force_taken = 1'b0;
    bit state_taken = 1'b0;
    int gap_left    = 0;
    int stall_left  = 0;

    // Predictor copy of registers and body state
    logic [DATA_W-1:0] inv_mass_q = ONE_Q;
    logic [DATA_W-1:0] dt_q       = ONE_Q;
    longint            pos_state [2]    = '{0, 0};
    longint            vel_state [2]    = '{0, 0};
    longint            accel_ring [3][2] = '{'{0, 0}, '{0, 0}, '{0, 0}};

    result_t want_state;

    beeman_integrator_2d #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .forces    (force_ch),
        .states    (state_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp to the signed 32-bit range
    function automatic longint clamp_s32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return longint'(32'sh7FFF_FFFF);
        if (v < -longint'(33'sh0_8000_0000))
            return -longint'(33'sh0_8000_0000);
        return v;
    endfunction

    // Advance both axes by one time step and queue the state it must produce
    task automatic advance_body(input force_t f_in);
        longint             dt;
        longint             im;
        longint             dt2;
        longint             f;
        longint             a0;
        longint             a1;
        longint             a2;
        longint             c6;
        longint             s6;
        longint             x;
        longint             v;
        logic [63:0]        dt2_wide;
        logic signed [31:0] force_axis [2];
        result_t            r;
        int                 ax;
        dt = {32'd0, dt_q};
        im = {32'd0, inv_mass_q};
        dt2_wide = ({32'd0, dt_q} * {32'd0, dt_q}) >> FRAC_BITS;
        dt2 = (dt2_wide > {32'd0, MAX_U32}) ? {32'd0, MAX_U32} : dt2_wide;
        force_axis[0] = f_in.force_x;
        force_axis[1] = f_in.force_y;
        for (ax = 0; ax < 2; ax++)
        begin
            f = force_axis[ax];
            accel_ring[0][ax] = accel_ring[1][ax];
            accel_ring[1][ax] = accel_ring[2][ax];
            accel_ring[2][ax] = clamp_s32((f * im) >>> FRAC_BITS);
            a0 = accel_ring[0][ax];
            a1 = accel_ring[1][ax];
            a2 = accel_ring[2][ax];
            // divide truncates toward zero on signed operands
            c6 = clamp_s32((4 * a1 - a0) / 6);
            s6 = clamp_s32((2 * a2 + 5 * a1 - a0) / 6);
            x = pos_state[ax];
            v = vel_state[ax];
            pos_state[ax] = clamp_s32(x + ((v * dt) >>> FRAC_BITS) + ((c6 * dt2) >>> FRAC_BITS));
            vel_state[ax] = clamp_s32(v + ((s6 * dt) >>> FRAC_BITS));
        end
        r.pos_x = pos_state[0][31:0];
        r.pos_y = pos_state[1][31:0];
        r.vel_x = vel_state[0][31:0];
        r.vel_y = vel_state[1][31:0];
        expected_states.push_back(r);
    endtask

    task automatic compare_field(input string field,
                                 input logic signed [DATA_W-1:0] want, got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_INV_MASS:    inv_mass_q = value;
            REG_STEP_SIZE:   dt_q = value;
            REG_START_POS_X: pos_state[0] = $signed(value);
            REG_START_POS_Y: pos_state[1] = $signed(value);
            REG_START_VEL_X: vel_state[0] = $signed(value);
            REG_START_VEL_Y: vel_state[1] = $signed(value);
            default:         ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_force(input logic [DATA_W-1:0] fx, input logic [DATA_W-1:0] fy);
        force_t item;
        item.force_x = fx;
        item.force_y = fy;
        force_queue.push_back(item);
        steps_queued++;
    endtask

    // Hold until every queued step has reported its state
    task automatic wait_drained();
        wait (steps_reported == steps_queued);
    endtask

    // Mix of full-range words, extremes and values spread over all magnitudes
    function automatic logic [DATA_W-1:0] draw_word(input bit as_signed);
        logic [DATA_W-1:0] w;
        case ($urandom_range(0, 7))
            0: w = $urandom;
            1:
            begin
                case ($urandom_range(0, 4))
                    0:       w = '0;
                    1:       w = 32'd1;
                    2:       w = MAX_U32;
                    3:       w = MAX_S32;
                    default: w = MIN_S32;
                endcase
            end
            default:
            begin
                w = $urandom >> $urandom_range(0, 31);
                if (as_signed && $urandom_range(0, 1))
                    w = -w;
            end
        endcase
        return w;
    endfunction

    // Force driver: present requests from the queue with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            force_ch.valid <= 1'b0;
        else if (!force_ch.valid || force_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                force_ch.valid <= 1'b0;
            end
            else if (force_queue.size() != 0)
            begin
                force_ch.data  <= force_queue.pop_front();
                force_ch.valid <= 1'b1;
                gap_left = pace_gaps ? $urandom_range(0, MAX_IDLE) : 0;
            end
            else
                force_ch.valid <= 1'b0;
        end
    end

    // State receiver: stall each request for a random number of cycles
    always @(negedge clk)
    begin
        if (!rst_n)
            state_ch.ready <= 1'b0;
        else
        begin
            if (state_taken)
                stall_left = pace_gaps ? $urandom_range(0, MAX_IDLE) : 0;
            else if (stall_left != 0 && state_ch.valid)
                stall_left--;
            state_ch.ready <= (stall_left == 0);
        end
    end

    // Monitor: predict on accepted forces, check accepted states
    always @(posedge clk)
    begin
        force_taken <= rst_n && force_ch.valid && force_ch.ready;
        state_taken <= rst_n && state_ch.valid && state_ch.ready;
        if (rst_n && force_ch.valid && force_ch.ready)
            advance_body(force_ch.data);
        if (rst_n && state_ch.valid && state_ch.ready)
        begin
            if (expected_states.size() == 0)
            begin
                $error("state request with no step pending: pos_x %0d pos_y %0d",
                       state_ch.data.pos_x, state_ch.data.pos_y);
                fail_count++;
            end
            else
            begin
                want_state = expected_states.pop_front();
                compare_field("pos_x", want_state.pos_x, state_ch.data.pos_x);
                compare_field("pos_y", want_state.pos_y, state_ch.data.pos_y);
                compare_field("vel_x", want_state.vel_x, state_ch.data.vel_x);
                compare_field("vel_y", want_state.vel_y, state_ch.data.vel_y);
            end
            steps_reported++;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_beeman_integrator_2d: FAIL");
        $finish;
    end

    initial
    begin
        cfg_reg_t reg_sel;
        int       random_steps;
        int       burst;
        random_steps = 0;
        cfg_we         = 1'b0;
        cfg_index      = REG_INV_MASS;
        cfg_data       = '0;
        force_ch.valid = 1'b0;
        force_ch.data  = '0;
        state_ch.ready = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: unit mass and step, body at rest at the origin
        queue_force('0, '0);
        queue_force(MAX_S32, MIN_S32);
        queue_force(MIN_S32, MAX_S32);
        queue_force(32'd1, MAX_U32);
        queue_force(MAX_U32, 32'd1);
        queue_force(ONE_Q, -ONE_Q);
        queue_force('0, '0);
        wait_drained();

        // Full-scale mass and step: dt squared saturates, start at the corners
        write_reg(REG_INV_MASS, MAX_U32);
        write_reg(REG_STEP_SIZE, MAX_U32);
        write_reg(REG_START_POS_X, MAX_S32);
        write_reg(REG_START_POS_Y, MIN_S32);
        write_reg(REG_START_VEL_X, MIN_S32);
        write_reg(REG_START_VEL_Y, MAX_S32);
        queue_force(32'd1, MAX_U32);
        queue_force(MAX_S32, MIN_S32);
        queue_force('0, '0);
        queue_force(MAX_U32, 32'd1);
        wait_drained();

        // Zero mass and step; spare indexes must leave everything alone
        write_reg(REG_INV_MASS, '0);
        write_reg(REG_STEP_SIZE, '0);
        write_reg(REG_SPARE_LO, MAX_U32);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        queue_force(MAX_S32, MIN_S32);
        queue_force(32'h0003_0039, 32'hFFFD_5D2A);
        wait_drained();

        // Moderate settings with a fresh start state loaded mid-run
        write_reg(REG_INV_MASS, ONE_Q >> 1);
        write_reg(REG_STEP_SIZE, ONE_Q >> 4);
        write_reg(REG_START_POS_X, 32'h0064_0000);
        write_reg(REG_START_POS_Y, -32'h0032_0000);
        write_reg(REG_START_VEL_X, 32'h0000_8000);
        write_reg(REG_START_VEL_Y, -32'h0002_0000);
        queue_force(32'h0010_0000, -32'h0008_0000);
        queue_force(-32'h0004_0000, 32'h0002_0000);
        queue_force(32'h0000_0001, -32'h0000_0001);
        queue_force('0, ONE_Q);
        queue_force(-ONE_Q, '0);
        wait_drained();

        // Random bursts, each under a partly rewritten set of registers
        while (random_steps < RANDOM_GOAL)
        begin
            pace_gaps = ($urandom_range(0, 3) != 0);
            reg_sel = reg_sel.first();
            do
            begin
                if ($urandom_range(0, 1))
                    write_reg(reg_sel,
                              draw_word(!(reg_sel inside {REG_INV_MASS, REG_STEP_SIZE})));
                reg_sel = reg_sel.next();
            end
            while (reg_sel != reg_sel.first());
            if ($urandom_range(0, 15) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            burst = $urandom_range(1, 60);
            repeat (burst)
                queue_force(draw_word(1'b1), draw_word(1'b1));
            random_steps += burst;
            wait_drained();
        end

        // Let any stray request show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_states.size() == 0)
            $display("tb_beeman_integrator_2d: PASS");
        else
            $display("tb_beeman_integrator_2d: FAIL");
        $finish;
    end

endmodule

// ===== beeman_integrator_2d.f =====
rtl/core/beem_pkg.sv
rtl/core/beem_stream_if.sv
rtl/core/beem_div6.sv
rtl/core/beem_datapath.sv
rtl/core/beem_ctrl.sv
rtl/core/beeman_integrator_2d.sv
rtl/core/beem_checker.sv
tb/tb_beeman_integrator_2d.sv
